FILE: hw/rtl/psafe_pkg.sv
package psafe_pkg;

  localparam int unsigned MsW    = 32;
  localparam int unsigned MvW    = 16;
  localparam int unsigned LevelW = 10;
  localparam int unsigned TempW  = 12;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CfgAddrW = 3;

  // Lowest safe water level: 5.0 percent in tenths.
  localparam logic [LevelW-1:0] LEVEL_MIN_DPCT = LevelW'(50);

  localparam logic [MsW-1:0] MS_MAX = '1;

  localparam logic [OpW-1:0] OP_TICK  = 3'd0;
  localparam logic [OpW-1:0] OP_ON    = 3'd1;
  localparam logic [OpW-1:0] OP_OFF   = 3'd2;
  localparam logic [OpW-1:0] OP_ESTOP = 3'd3;
  localparam logic [OpW-1:0] OP_BEGIN = 3'd4;

  localparam logic [CfgAddrW-1:0] CFG_MIN_ON   = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_MAX_ON   = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_COOLDOWN = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_BATT_CRIT = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_SHUT_TEMP = 3'd4;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_COOL = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [MsW-1:0]          min_on_ms;
    logic [MsW-1:0]          max_on_ms;
    logic [MsW-1:0]          cooldown_ms;
    logic [MvW-1:0]          battery_critical_mv;
    logic signed [TempW-1:0] shutdown_temp_dc;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic [MsW-1:0]          duration_ms;
    logic                    woke_from_sleep;
    logic                    in_maintenance;
    logic [MvW-1:0]          battery_mv;
    logic [LevelW-1:0]       water_level_dpct;
    logic signed [TempW-1:0] water_temp_dc;
  } item_t;

  typedef struct packed {
    mode_t          pump_mode;
    logic           relay_on;
    logic           accepted;
    logic [MsW-1:0] time_remaining_ms;
    logic [MsW-1:0] total_runtime_ms;
    logic           can_run;
  } result_t;

endpackage

FILE: hw/rtl/pump_safety_timer_controller_top.sv
// Pump relay safety controller. Every input transaction (a 1 ms tick or a
// command, with the current sensor readings) yields exactly one result
// transaction with the mode, relay drive and status after it is applied.
// One transaction is taken per clock while in_stall is low. The input
// register captures a transaction when it is accepted, and the result
// register captures the combinational update of the mode and timers, which
// is presented as the result. A stalled result holds the input
// register, so the input stalls once both registers are full. The
// configuration registers are written through cfg_we/cfg_addr/cfg_wdata and
// should only be changed while no transaction is in flight.
module pump_safety_timer_controller_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [psafe_pkg::OpW-1:0]              in_op,
  input  logic [psafe_pkg::MsW-1:0]              in_duration_ms,
  input  logic                                   in_woke_from_sleep,
  input  logic                                   in_in_maintenance,
  input  logic [psafe_pkg::MvW-1:0]              in_battery_mv,
  input  logic [psafe_pkg::LevelW-1:0]           in_water_level_dpct,
  input  logic signed [psafe_pkg::TempW-1:0]     in_water_temp_dc,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_pump_mode,
  output logic                                   out_relay_on,
  output logic                                   out_accepted,
  output logic [psafe_pkg::MsW-1:0]              out_time_remaining_ms,
  output logic [psafe_pkg::MsW-1:0]              out_total_runtime_ms,
  output logic                                   out_can_run,
  input  logic                                   cfg_we,
  input  logic [psafe_pkg::CfgAddrW-1:0]         cfg_addr,
  input  logic [psafe_pkg::MsW-1:0]              cfg_wdata
);

  psafe_pkg::cfg_t     cfg;
  psafe_pkg::item_t    item_r;
  psafe_pkg::result_t  res;
  psafe_pkg::result_t  res_r;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                out_free;
  logic                fire;
  logic                in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  psafe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  psafe_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op               <= in_op;
      item_r.duration_ms      <= in_duration_ms;
      item_r.woke_from_sleep  <= in_woke_from_sleep;
      item_r.in_maintenance   <= in_in_maintenance;
      item_r.battery_mv       <= in_battery_mv;
      item_r.water_level_dpct <= in_water_level_dpct;
      item_r.water_temp_dc    <= in_water_temp_dc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pump_mode         = res_r.pump_mode;
  assign out_relay_on          = res_r.relay_on;
  assign out_accepted          = res_r.accepted;
  assign out_time_remaining_ms = res_r.time_remaining_ms;
  assign out_total_runtime_ms  = res_r.total_runtime_ms;
  assign out_can_run           = res_r.can_run;

endmodule

FILE: hw/rtl/psafe_cfg.sv
module psafe_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [psafe_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [psafe_pkg::MsW-1:0]           cfg_wdata,
  output psafe_pkg::cfg_t                     cfg
);

  psafe_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_on_ms           <= psafe_pkg::MsW'(1000);
      cfg_r.max_on_ms           <= psafe_pkg::MsW'(60000);
      cfg_r.cooldown_ms         <= psafe_pkg::MsW'(300000);
      cfg_r.battery_critical_mv <= psafe_pkg::MvW'(11000);
      cfg_r.shutdown_temp_dc    <= psafe_pkg::TempW'(400);
    end else if (cfg_we) begin
      case (cfg_addr)
        psafe_pkg::CFG_MIN_ON:    cfg_r.min_on_ms   <= cfg_wdata;
        psafe_pkg::CFG_MAX_ON:    cfg_r.max_on_ms   <= cfg_wdata;
        psafe_pkg::CFG_COOLDOWN:  cfg_r.cooldown_ms <= cfg_wdata;
        psafe_pkg::CFG_BATT_CRIT:
          cfg_r.battery_critical_mv <= cfg_wdata[psafe_pkg::MvW-1:0];
        psafe_pkg::CFG_SHUT_TEMP:
          cfg_r.shutdown_temp_dc <= $signed(cfg_wdata[psafe_pkg::TempW-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/psafe_core.sv
module psafe_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  psafe_pkg::item_t    item,
  input  psafe_pkg::cfg_t     cfg,
  output psafe_pkg::result_t  res
);

  psafe_pkg::mode_t           mode_r, mode_nxt;
  logic [psafe_pkg::MsW-1:0]  run_el_r, run_el_nxt;
  logic [psafe_pkg::MsW-1:0]  run_len_r, run_len_nxt;
  logic                       timed_r, timed_nxt;
  logic [psafe_pkg::MsW-1:0]  rest_el_r, rest_el_nxt;
  logic [psafe_pkg::MsW-1:0]  sum_r, sum_nxt;

  logic                       safe;
  logic [psafe_pkg::MsW-1:0]  run_inc, rest_inc;
  logic [psafe_pkg::MsW:0]    sum_wide;
  logic [psafe_pkg::MsW-1:0]  sum_sat;
  logic [psafe_pkg::MsW-1:0]  start_req, start_len;

  assign safe = !item.in_maintenance
             && (item.battery_mv >= cfg.battery_critical_mv)
             && (item.water_level_dpct >= psafe_pkg::LEVEL_MIN_DPCT)
             && (item.water_temp_dc <= cfg.shutdown_temp_dc);

  assign run_inc  = (run_el_r == psafe_pkg::MS_MAX) ? run_el_r : run_el_r + 1'b1;
  assign rest_inc = (rest_el_r == psafe_pkg::MS_MAX) ? rest_el_r : rest_el_r + 1'b1;

  // Only a tick ends a run with the incremented count; turn off uses the held one.
  always_comb begin
    sum_wide = {1'b0, sum_r}
             + {1'b0, ((item.op == psafe_pkg::OP_TICK) ? run_inc : run_el_r)};
    sum_sat  = sum_wide[psafe_pkg::MsW] ? psafe_pkg::MS_MAX
                                        : sum_wide[psafe_pkg::MsW-1:0];
  end

  // Clamp to min first, then max, so max wins when the limits cross.
  always_comb begin
    start_req = (item.op == psafe_pkg::OP_TICK) ? cfg.max_on_ms : item.duration_ms;
    start_len = start_req;
    if (start_len < cfg.min_on_ms) begin
      start_len = cfg.min_on_ms;
    end
    if (start_len > cfg.max_on_ms) begin
      start_len = cfg.max_on_ms;
    end
  end

  // Next state.
  always_comb begin
    mode_nxt    = mode_r;
    run_el_nxt  = run_el_r;
    run_len_nxt = run_len_r;
    timed_nxt   = timed_r;
    rest_el_nxt = rest_el_r;
    sum_nxt     = sum_r;
    if (fire) begin
      case (item.op)
        psafe_pkg::OP_TICK: begin
          run_el_nxt  = run_inc;
          rest_el_nxt = rest_inc;
          case (mode_r)
            psafe_pkg::MODE_ON: begin
              if (timed_r && (run_inc >= run_len_r)) begin
                sum_nxt     = sum_sat;
                rest_el_nxt = '0;
                mode_nxt    = psafe_pkg::MODE_COOL;
              end
              if (!safe) begin
                mode_nxt = psafe_pkg::MODE_ERR;
              end
            end
            psafe_pkg::MODE_COOL: begin
              if (rest_inc >= cfg.cooldown_ms) begin
                if (!safe) begin
                  mode_nxt = psafe_pkg::MODE_ERR;
                end else begin
                  timed_nxt   = (start_req != '0);
                  run_len_nxt = (start_req != '0) ? start_len : '0;
                  run_el_nxt  = '0;
                  mode_nxt    = psafe_pkg::MODE_ON;
                end
              end
            end
            psafe_pkg::MODE_ERR: begin
              if (safe) begin
                mode_nxt = psafe_pkg::MODE_COOL;
              end
            end
            default: ;
          endcase
        end
        psafe_pkg::OP_ON: begin
          if (!safe) begin
            mode_nxt = psafe_pkg::MODE_ERR;
          end else begin
            timed_nxt   = (start_req != '0);
            run_len_nxt = (start_req != '0) ? start_len : '0;
            run_el_nxt  = '0;
            mode_nxt    = psafe_pkg::MODE_ON;
          end
        end
        psafe_pkg::OP_OFF: begin
          if (mode_r == psafe_pkg::MODE_ON) begin
            sum_nxt     = sum_sat;
            rest_el_nxt = '0;
            mode_nxt    = psafe_pkg::MODE_COOL;
          end
        end
        psafe_pkg::OP_ESTOP: begin
          mode_nxt = psafe_pkg::MODE_ERR;
        end
        psafe_pkg::OP_BEGIN: begin
          rest_el_nxt = item.woke_from_sleep ? cfg.cooldown_ms : '0;
          mode_nxt    = psafe_pkg::MODE_COOL;
        end
        default: ;
      endcase
    end
  end

  // Status reported after the transaction is applied.
  always_comb begin
    res.pump_mode        = mode_nxt;
    res.relay_on         = (mode_nxt == psafe_pkg::MODE_ON);
    res.accepted         = (item.op == psafe_pkg::OP_ON) && safe;
    res.time_remaining_ms = '0;
    if ((mode_nxt == psafe_pkg::MODE_ON) && timed_nxt && (run_el_nxt < run_len_nxt)) begin
      res.time_remaining_ms = run_len_nxt - run_el_nxt;
    end
    res.total_runtime_ms = sum_nxt;
    res.can_run          = (mode_nxt == psafe_pkg::MODE_OFF) && safe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= psafe_pkg::MODE_OFF;
      run_el_r  <= '0;
      run_len_r <= '0;
      timed_r   <= 1'b0;
      rest_el_r <= '0;
      sum_r     <= '0;
    end else begin
      mode_r    <= mode_nxt;
      run_el_r  <= run_el_nxt;
      run_len_r <= run_len_nxt;
      timed_r   <= timed_nxt;
      rest_el_r <= rest_el_nxt;
      sum_r     <= sum_nxt;
    end
  end

  a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sum_r >= $past(sum_r)))
    else $error("runtime sum decreased");

  a_mode_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(fire)) |-> $stable(mode_r))
    else $error("mode changed without a transaction");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.accepted) |=> (mode_r == psafe_pkg::MODE_ON) && (run_el_r == '0))
    else $error("accepted turn on did not start a run");

  a_remaining_on: assert property (@(posedge clk) disable iff (!rst_n)
    (res.time_remaining_ms != '0) |-> (res.pump_mode == psafe_pkg::MODE_ON) && timed_nxt)
    else $error("time remaining outside a timed run");

endmodule
